// ===== design/rsip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsip_pkg
// Shared types, character codes and the digit decoder of the radix string
// parser.
// ----------------------------------------------------------------------------
package rsip_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned RADIX_W = 5;
  localparam int unsigned DIGIT_W = 6;

  // Character codes that steer the parse.
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_SEVEN = 8'h37;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LC_B  = 8'h62;
  localparam logic [CHAR_W-1:0] CHAR_LC_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CHAR_LC_Z  = 8'h7A;

  // Radix codes.
  localparam logic [RADIX_W-1:0] RADIX_AUTO = 5'd0;
  localparam logic [RADIX_W-1:0] RADIX_ONE  = 5'd1;
  localparam logic [RADIX_W-1:0] RADIX_BIN  = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_OCT  = 5'd8;
  localparam logic [RADIX_W-1:0] RADIX_DEC  = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX  = 5'd16;

  // Digit value of a character that is no digit at all.
  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'd63;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;

  // Parse phase within one string.
  typedef enum logic [2:0] {
    PH_START        = 3'd0,
    PH_LEAD_ZERO    = 3'd1,
    PH_AFTER_PREFIX = 3'd2,
    PH_ZERO_END     = 3'd3,
    PH_DIGITS       = 3'd4
  } phase_e;

  // Maps a character to its digit value: 0..9, then 10..35 for letters.
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d = DIGIT_W'(c - CHAR_ZERO);
    end else if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
      d = DIGIT_W'(c - CHAR_UC_A) + DIGIT_TEN;
    end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
      d = DIGIT_W'(c - CHAR_LC_A) + DIGIT_TEN;
    end else begin
      d = DIGIT_NONE;
    end
    return d;
  endfunction

endpackage

// ===== design/rsip_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsip_if
// Valid/ready channels of the radix string parser: characters in, results
// out, and the radix configuration write.
// ----------------------------------------------------------------------------

// One character per item.
interface rsip_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

// One parsed number per item.
interface rsip_result_if #(
  parameter int unsigned VALUE_WIDTH = 64
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] parsed_value;
  logic                   parse_status;
  modport source (output valid, output parsed_value, output parse_status, input ready);
  modport sink   (input valid, input parsed_value, input parse_status, output ready);
endinterface

// Write of the radix mode register.
interface rsip_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] radix_mode;
  modport source (output valid, output radix_mode, input ready);
  modport sink   (input valid, input radix_mode, output ready);
endinterface

// ===== design/rsip_digit_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsip_digit_mac
// Decodes one character as a digit and folds it into the accumulator:
// acc * radix + digit, flagging a bad digit, a bad radix or an overflow.
// ----------------------------------------------------------------------------
module rsip_digit_mac #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic [VALUE_WIDTH-1:0]      acc_i,
  input  logic [rsip_pkg::CHAR_W-1:0]  char_i,
  input  logic [rsip_pkg::RADIX_W-1:0] radix_i,
  output logic [VALUE_WIDTH-1:0]      acc_o,
  output logic                        bad_o
);
  import rsip_pkg::*;

  localparam int unsigned PROD_W = VALUE_WIDTH + RADIX_W;

  logic [DIGIT_W-1:0] digit;
  logic [PROD_W-1:0]  prod;
  logic               digit_bad;
  logic               overflow;

  // Digit decode and range check against the radix.
  assign digit     = digit_of(char_i);
  assign digit_bad = (radix_i < RADIX_BIN) || (digit >= DIGIT_W'(radix_i));

  // Multiply-add; any bit above the value width means overflow.
  assign prod     = PROD_W'(acc_i) * PROD_W'(radix_i) + PROD_W'(digit);
  assign overflow = |prod[PROD_W-1:VALUE_WIDTH];

  assign acc_o = prod[VALUE_WIDTH-1:0];
  assign bad_o = digit_bad || overflow;

endmodule

// ===== design/radix_string_to_integer_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_string_to_integer_parser
// Character-serial unsigned integer parser with fixed radix 2..16 or radix
// detection from a 0x / 0b / 0 prefix. Emits one result per NUL character.
// ----------------------------------------------------------------------------
//  channel   dir  payload                      item
//  char_i    in   char_code[7:0]               one character, NUL ends string
//  result_o  out  parsed_value, parse_status   one number per string
//  cfg_i     in   radix_mode[4:0]              radix register write
//
//  A character is registered at the input, then processed by one multiply-add
//  of the accumulator by the radix (a VALUE_WIDTH x 5 multiplier), so one
//  item per cycle is sustained while no NUL is held back; an accepted NUL
//  passes the input register and then the result register before it is valid.
//  A NUL waits in the input register while the result register is full and
//  not taken; other characters pass freely. Reset clears the parse state and
//  the radix mode (auto detect). cfg_i is always ready.
// ----------------------------------------------------------------------------
module radix_string_to_integer_parser #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  rsip_char_if.sink       char_i,
  rsip_result_if.source   result_o,
  rsip_cfg_if.sink        cfg_i
);
  import rsip_pkg::*;

  logic [RADIX_W-1:0]     mode_q;
  logic                   in_valid_q;
  logic [CHAR_W-1:0]      char_q;
  phase_e                 phase_q, phase_d;
  logic [RADIX_W-1:0]     radix_q, radix_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic                   err_q, err_d;
  logic                   res_valid_q;
  logic [VALUE_WIDTH-1:0] res_value_q, res_value_d;
  logic                   res_status_q, res_status_d;

  logic                   is_nul;
  logic                   advance;
  logic                   emit;
  logic [RADIX_W-1:0]     mac_radix;
  logic [VALUE_WIDTH-1:0] mac_acc;
  logic                   mac_bad;

  // Configuration register.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= RADIX_AUTO;
    end else if (cfg_i.valid) begin
      mode_q <= cfg_i.radix_mode;
    end
  end

  // Handshake: a NUL needs a free result slot, other characters do not.
  assign is_nul         = (char_q == CHAR_NUL);
  assign advance        = in_valid_q && (!is_nul || !res_valid_q || result_o.ready);
  assign emit           = advance && is_nul;
  assign char_i.ready   = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (char_i.ready) begin
      in_valid_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      char_q <= char_i.char_code;
    end
  end

  // Radix fed to the multiply-add for the current character.
  always_comb begin
    case (phase_q)
      PH_START:     mac_radix = (mode_q == RADIX_AUTO) ? RADIX_DEC : mode_q;
      PH_LEAD_ZERO: mac_radix = RADIX_OCT;
      default:      mac_radix = radix_q;
    endcase
  end

  rsip_digit_mac #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_mac (
    .acc_i   (acc_q),
    .char_i  (char_q),
    .radix_i (mac_radix),
    .acc_o   (mac_acc),
    .bad_o   (mac_bad)
  );

  // Parse state machine: next state and result.
  always_comb begin
    phase_d      = phase_q;
    radix_d      = radix_q;
    acc_d        = acc_q;
    err_d        = err_q;
    res_status_d = err_q || (phase_q == PH_START) || (phase_q == PH_AFTER_PREFIX);
    res_value_d  = (res_status_d || phase_q == PH_LEAD_ZERO || phase_q == PH_ZERO_END)
                   ? '0 : acc_q;
    if (is_nul) begin
      phase_d = PH_START;
      radix_d = RADIX_AUTO;
      acc_d   = '0;
      err_d   = 1'b0;
    end else if (!err_q) begin
      unique case (phase_q)
        PH_START: begin
          radix_d = mode_q;
          if (char_q == CHAR_ZERO) begin
            phase_d = PH_LEAD_ZERO;
          end else if (mode_q == RADIX_ONE || mode_q > RADIX_HEX) begin
            err_d = 1'b1;
          end else begin
            radix_d = mac_radix;
            phase_d = PH_DIGITS;
            if (mac_bad) begin
              err_d = 1'b1;
            end else begin
              acc_d = mac_acc;
            end
          end
        end
        PH_LEAD_ZERO: begin
          if (radix_q != RADIX_AUTO) begin
            err_d = 1'b1;
          end else if (char_q == CHAR_LC_X) begin
            radix_d = RADIX_HEX;
            phase_d = PH_AFTER_PREFIX;
          end else if (char_q == CHAR_LC_B) begin
            radix_d = RADIX_BIN;
            phase_d = PH_AFTER_PREFIX;
          end else if (char_q >= CHAR_ZERO && char_q <= CHAR_SEVEN) begin
            radix_d = RADIX_OCT;
            if (char_q == CHAR_ZERO) begin
              phase_d = PH_ZERO_END;
            end else begin
              phase_d = PH_DIGITS;
              acc_d   = mac_acc;
            end
          end else begin
            err_d = 1'b1;
          end
        end
        PH_AFTER_PREFIX: begin
          if (char_q == CHAR_ZERO) begin
            phase_d = PH_ZERO_END;
          end else begin
            phase_d = PH_DIGITS;
            if (mac_bad) begin
              err_d = 1'b1;
            end else begin
              acc_d = mac_acc;
            end
          end
        end
        PH_DIGITS: begin
          if (mac_bad) begin
            err_d = 1'b1;
          end else begin
            acc_d = mac_acc;
          end
        end
        default: begin
          err_d = 1'b1;
        end
      endcase
    end
  end

  // Parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      radix_q <= RADIX_AUTO;
      acc_q   <= '0;
      err_q   <= 1'b0;
    end else if (advance) begin
      phase_q <= phase_d;
      radix_q <= radix_d;
      acc_q   <= acc_d;
      err_q   <= err_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (emit) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_value_q  <= res_value_d;
      res_status_q <= res_status_d;
    end
  end

  assign result_o.valid        = res_valid_q;
  assign result_o.parsed_value = res_value_q;
  assign result_o.parse_status = res_status_q;

  // An invalid result always carries a zero value.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_status_q |-> res_value_q == '0)
    else $error("invalid result with nonzero value");

  // At the start of a string the accumulator is empty.
  a_start_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_START |-> acc_q == '0)
    else $error("accumulator not clear at string start");

  // A clean string start has no radix chosen yet.
  a_start_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_START && !err_q |-> radix_q == RADIX_AUTO)
    else $error("radix set at clean string start");

  // While in the digits the radix is a usable one.
  a_digit_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DIGITS |-> radix_q >= RADIX_BIN && radix_q <= RADIX_HEX)
    else $error("unusable radix in digit phase");

endmodule

// ===== verif/tb_radix_string_to_integer_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radix_string_to_integer_parser
// Feeds NUL-terminated strings to the radix string parser, one character per
// item, under a range of radix settings. A behavioral model inside the
// scoreboard class predicts each parsed number and status, and every result
// item is checked field by field against the oldest prediction. Both sides
// stall in random bursts, except in the last part of the run.
// ----------------------------------------------------------------------------
module tb_radix_string_to_integer_parser;
  import rsip_pkg::*;

  localparam int unsigned VW          = 64;
  localparam int unsigned NOT_A_DIGIT = 99;
  localparam int unsigned CHAR_TARGET = 700;
  localparam int unsigned CALM_AFTER  = 560;

  typedef struct packed {
    logic [VW-1:0] value;
    logic          status;
  } parsed_number_t;

  // Predicts the parser item by item and checks its results in order.
  class parsed_number_board;
    logic [RADIX_W-1:0] mode_reg;
    phase_e             phase;
    logic [RADIX_W-1:0] radix;
    logic [VW-1:0]      acc;
    bit                 bad_seen;
    parsed_number_t     awaited_numbers[$];
    int unsigned        errors;

    function new();
      mode_reg = RADIX_AUTO;
      errors   = 0;
      restart();
    endfunction

    function void restart();
      phase    = PH_START;
      radix    = RADIX_AUTO;
      acc      = '0;
      bad_seen = 1'b0;
    endfunction

    function void set_mode(logic [RADIX_W-1:0] m);
      mode_reg = m;
    endfunction

    function int unsigned pending();
      return awaited_numbers.size();
    endfunction

    function int unsigned digit_value(logic [CHAR_W-1:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
      if (c >= CHAR_UC_A && c <= CHAR_UC_Z) return int'(c - CHAR_UC_A) + 10;
      if (c >= CHAR_LC_A && c <= CHAR_LC_Z) return int'(c - CHAR_LC_A) + 10;
      return NOT_A_DIGIT;
    endfunction

    // One multiply-add; a bad digit or a carry out of VW bits spoils the string.
    function void add_digit(logic [CHAR_W-1:0] c);
      int unsigned   d;
      logic [VW+5:0] wide;
      d = digit_value(c);
      if (radix < RADIX_BIN || d >= radix) begin
        bad_seen = 1'b1;
        return;
      end
      wide = (VW+6)'(acc) * (VW+6)'(radix) + (VW+6)'(d);
      if (wide[VW+5:VW] != '0) begin
        bad_seen = 1'b1;
      end else begin
        acc = wide[VW-1:0];
      end
    endfunction

    // Takes one accepted character; returns 0 when the item is ignored.
    function bit note_char(logic [CHAR_W-1:0] c);
      parsed_number_t res;
      if (c == CHAR_NUL) begin
        res.value  = acc;
        res.status = bad_seen;
        if (phase == PH_START || phase == PH_AFTER_PREFIX) begin
          res.status = 1'b1;
        end else if (phase == PH_LEAD_ZERO || phase == PH_ZERO_END) begin
          res.value = '0;
        end
        if (res.status) res.value = '0;
        awaited_numbers.push_back(res);
        restart();
        return 1'b1;
      end
      if (bad_seen) return 1'b0;
      case (phase)
        PH_START: begin
          radix = mode_reg;
          if (c == CHAR_ZERO) begin
            phase = PH_LEAD_ZERO;
          end else if (radix == RADIX_ONE || radix > RADIX_HEX) begin
            bad_seen = 1'b1;
          end else begin
            if (radix == RADIX_AUTO) radix = RADIX_DEC;
            phase = PH_DIGITS;
            add_digit(c);
          end
        end
        PH_LEAD_ZERO: begin
          if (radix != RADIX_AUTO) begin
            bad_seen = 1'b1;
          end else if (c == CHAR_LC_X) begin
            radix = RADIX_HEX;
            phase = PH_AFTER_PREFIX;
          end else if (c == CHAR_LC_B) begin
            radix = RADIX_BIN;
            phase = PH_AFTER_PREFIX;
          end else if (c >= CHAR_ZERO && c <= CHAR_SEVEN) begin
            radix = RADIX_OCT;
            if (c == CHAR_ZERO) begin
              phase = PH_ZERO_END;
            end else begin
              phase = PH_DIGITS;
              add_digit(c);
            end
          end else begin
            bad_seen = 1'b1;
          end
        end
        PH_AFTER_PREFIX: begin
          if (c == CHAR_ZERO) begin
            phase = PH_ZERO_END;
          end else begin
            phase = PH_DIGITS;
            add_digit(c);
          end
        end
        PH_DIGITS: begin
          add_digit(c);
        end
        default: begin
          // A zero that had to end the string was followed by more text.
          bad_seen = 1'b1;
        end
      endcase
      return 1'b1;
    endfunction

    function void check_result(logic [VW-1:0] value, logic status);
      parsed_number_t want;
      if (awaited_numbers.size() == 0) begin
        $error("unexpected result item: parsed_value %0d, parse_status %0d",
               value, status);
        errors++;
        return;
      end
      want = awaited_numbers.pop_front();
      if (value !== want.value) begin
        $error("parsed_value: expected %0d, got %0d", want.value, value);
        errors++;
      end
      if (status !== want.status) begin
        $error("parse_status: expected %0d, got %0d", want.status, status);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  rsip_char_if                         ch ();
  rsip_result_if #(.VALUE_WIDTH(VW))   rs ();
  rsip_cfg_if                          cfg ();

  radix_string_to_integer_parser #(
    .VALUE_WIDTH(VW)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (ch),
    .result_o(rs),
    .cfg_i   (cfg)
  );

  parsed_number_board board = new();
  logic [CHAR_W-1:0]  text_buf[$];
  int unsigned        chars_sent = 0;
  bit                 calm = 1'b0;

  // Clock with a 12 ns period.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Result side: checks each accepted item and stalls in random bursts.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    rs.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rs.valid && rs.ready) board.check_result(rs.parsed_value, rs.parse_status);
      if (stall_left > 0 && !calm) begin
        stall_left--;
        rs.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        rs.ready <= 1'b0;
      end else begin
        rs.ready <= 1'b1;
      end
    end
  end

  // Sends one character, with an occasional idle burst in front of it.
  task automatic send_char(logic [CHAR_W-1:0] c);
    if (!calm && $urandom_range(0, 4) == 0) begin
      ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    ch.valid     <= 1'b1;
    ch.char_code <= c;
    do @(posedge clk_i); while (!ch.ready);
    if (board.note_char(c)) chars_sent++;
    if (chars_sent >= CALM_AFTER) calm = 1'b1;
  endtask

  task automatic send_string();
    foreach (text_buf[i]) send_char(text_buf[i]);
    send_char(CHAR_NUL);
    text_buf.delete();
  endtask

  // The register is written only once the parser has drained.
  task automatic write_radix_mode(logic [RADIX_W-1:0] m);
    ch.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg.valid      <= 1'b1;
    cfg.radix_mode <= m;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    board.set_mode(m);
  endtask

  function automatic logic [CHAR_W-1:0] digit_char(int unsigned d);
    if (d < 10) return CHAR_ZERO + CHAR_W'(d);
    return ($urandom_range(0, 1) ? CHAR_UC_A : CHAR_LC_A) + CHAR_W'(d - 10);
  endfunction

  function automatic logic [CHAR_W-1:0] random_char();
    if ($urandom_range(0, 1)) return CHAR_W'($urandom_range(1, 255));
    return digit_char($urandom_range(0, 35));
  endfunction

  // Number of digits of the largest value in radix r.
  function automatic int unsigned max_len(int unsigned r);
    logic [VW-1:0] v;
    int unsigned   n;
    v = '1;
    n = 0;
    while (v != '0) begin
      v = v / r;
      n++;
    end
    return n;
  endfunction

  function automatic void push_random_digits(int unsigned r, int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      text_buf.push_back(digit_char(i == 0 ? $urandom_range(1, r - 1)
                                           : $urandom_range(0, r - 1)));
    end
  endfunction

  // Largest value in radix r, or one above it when bump is set and its last digit is below r - 1.
  function automatic void push_max_digits(int unsigned r, bit bump);
    logic [VW-1:0] v;
    int unsigned   dig[$];
    v = '1;
    while (v != '0) begin
      dig.push_front(32'(v % r));
      v = v / r;
    end
    if (bump && dig[dig.size()-1] < r - 1) dig[dig.size()-1]++;
    foreach (dig[i]) text_buf.push_back(digit_char(dig[i]));
  endfunction

  // A number string for the given mode, with prefixes in auto mode and decimal digits in an unusable mode.
  function automatic void build_number(logic [RADIX_W-1:0] m);
    int unsigned r;
    int unsigned sel;
    r = m;
    if (m == RADIX_AUTO) begin
      case ($urandom_range(0, 3))
        0: begin
          text_buf.push_back(CHAR_ZERO);
          text_buf.push_back(CHAR_LC_X);
          r = RADIX_HEX;
        end
        1: begin
          text_buf.push_back(CHAR_ZERO);
          text_buf.push_back(CHAR_LC_B);
          r = RADIX_BIN;
        end
        2: begin
          text_buf.push_back(CHAR_ZERO);
          r = RADIX_OCT;
        end
        default: r = RADIX_DEC;
      endcase
    end else if (m == RADIX_ONE || m > RADIX_HEX) begin
      r = RADIX_DEC;
    end
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      text_buf.push_back(CHAR_ZERO);
    end else if (sel < 72) begin
      push_random_digits(r, $urandom_range(1, 6));
    end else if (sel < 88) begin
      push_random_digits(r, max_len(r));
    end else begin
      push_max_digits(r, $urandom_range(0, 1));
    end
  endfunction

  // Mostly well-formed strings; the rest are damaged or plain noise.
  function automatic void build_string(logic [RADIX_W-1:0] m);
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 75) begin
      build_number(m);
    end else if (kind < 88) begin
      build_number(m);
      case ($urandom_range(0, 2))
        0: text_buf[$urandom_range(0, text_buf.size() - 1)] = random_char();
        1: text_buf.push_back(random_char());
        default: text_buf.push_front(CHAR_ZERO);
      endcase
    end else begin
      repeat ($urandom_range(0, 5)) text_buf.push_back(random_char());
    end
  endfunction

  // Stimulus: reset, directed special cases, then random phases.
  initial begin
    logic [RADIX_W-1:0] schedule[$];
    logic [RADIX_W-1:0] m;
    int unsigned        phase_idx;
    schedule = '{RADIX_AUTO, RADIX_HEX, RADIX_BIN, RADIX_DEC, RADIX_OCT,
                 RADIX_ONE, 5'd31, 5'd17, RADIX_AUTO};
    ch.valid       <= 1'b0;
    ch.char_code   <= CHAR_NUL;
    cfg.valid      <= 1'b0;
    cfg.radix_mode <= RADIX_AUTO;
    rst_ni         <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Auto mode straight after reset: empty string, lone zero, bare prefix,
    // zero after a prefix, double zero, octal, and a high non-digit code.
    send_string();
    text_buf = '{CHAR_ZERO};
    send_string();
    text_buf = '{CHAR_ZERO, CHAR_LC_X};
    send_string();
    text_buf = '{CHAR_ZERO, CHAR_LC_X, CHAR_ZERO};
    send_string();
    text_buf = '{CHAR_ZERO, CHAR_ZERO};
    send_string();
    text_buf = '{CHAR_ZERO, "1", CHAR_SEVEN};
    send_string();
    text_buf = '{CHAR_ZERO, 8'hFF};
    send_string();
    // Fixed radix with a leading zero, then the unusable radix settings.
    write_radix_mode(RADIX_BIN);
    text_buf = '{CHAR_ZERO, "1"};
    send_string();
    write_radix_mode(RADIX_ONE);
    text_buf = '{"5"};
    send_string();
    write_radix_mode(5'd31);
    text_buf = '{CHAR_ZERO};
    send_string();

    // Random phases, each under one radix setting.
    phase_idx = 0;
    while (chars_sent < CHAR_TARGET) begin
      if (phase_idx < schedule.size()) begin
        m = schedule[phase_idx];
      end else if ($urandom_range(0, 9) < 8) begin
        m = RADIX_W'($urandom_range(1, 16));
        if (m == RADIX_ONE) m = RADIX_AUTO;
      end else begin
        m = $urandom_range(0, 1) ? RADIX_ONE : RADIX_W'($urandom_range(17, 31));
      end
      write_radix_mode(m);
      repeat ($urandom_range(4, 10)) begin
        build_string(m);
        send_string();
      end
      phase_idx++;
    end

    // Drain and report.
    ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog for a run that hangs.
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule
